### rtl/core/sitda_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sitda_pkg
// shared types and constants for the signed integer to decimal text converter
// ----------------------------------------------------------------------------
package sitda_pkg;

  localparam int unsigned ValueWidth  = 32;
  localparam int unsigned CharWidth   = 6;
  localparam int unsigned NumDigits   = 10;
  localparam int unsigned StepBits    = 3;
  // conversion steps: enough 3-bit slices to cover the magnitude plus a pad
  localparam int unsigned NumSteps    = (ValueWidth + StepBits - 1) / StepBits;
  localparam int unsigned ShiftWidth  = NumSteps * StepBits;
  localparam int unsigned StepCntW    = $clog2(NumSteps);
  localparam int unsigned DigitIdxW   = $clog2(NumDigits);

  localparam logic [CharWidth-1:0] ZeroCode  = 6'd48;
  localparam logic [CharWidth-1:0] MinusCode = 6'd45;

  typedef logic [3:0] bcd_t;

  // finished conversion handed from the converter to the emitter
  typedef struct packed {
    logic                     neg;
    bcd_t [NumDigits-1:0]     digits;
  } conv_res_t;

endpackage

### rtl/core/signed_int_to_decimal_ascii.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii
// signed 32-bit integer to decimal ascii text, one character per beat
// ----------------------------------------------------------------------------
// channel   dir  tdata                         tuser  tlast
// s_axis    in   [31:0] value (signed)         -      -
// m_axis    out  [5:0] char_code, [7:6] zero   -      last_char
//
// during conversion the row of ten digit cells absorbs three
// magnitude bits per cycle (shift-and-add-3).
// the result is then handed to the emitter, which sends 1 to 11 beats, one
// per cycle while m_axis_tready is high; the next value converts while the
// previous one is emitted, so the sustained rate is set by the cell row.
// reset is asynchronous and active low; no clearing pass is needed.
// a stall on m_axis holds the character; s_axis_tready is low while the cell
// row converts, and stays low while a finished value waits for the emitter.
// ----------------------------------------------------------------------------
module signed_int_to_decimal_ascii (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [31:0] value
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [5:0] char_code, [7:6] zero fill
  output logic        m_axis_tlast    // last_char
);

  // converter to emitter hand-off
  sitda_pkg::conv_res_t                 res;
  logic                                 res_valid;
  logic                                 res_ready;
  logic [sitda_pkg::CharWidth-1:0]      char_code;

  // front end: magnitude and sign, then the digit cell row
  sitda_conv u_conv (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_value_i  (s_axis_tdata),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res)
  );

  // back end: sign beat, then significant digits from most significant down
  sitda_emit u_emit (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_valid_i (res_valid),
    .res_ready_o (res_ready),
    .res_i       (res),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_char_o  (char_code),
    .out_last_o  (m_axis_tlast)
  );

  assign m_axis_tdata = {2'b00, char_code};

endmodule

### rtl/core/sitda_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sitda_cell
// one decimal digit of the shift-and-add-3 chain, three shifts per cycle
// ----------------------------------------------------------------------------
module sitda_cell (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             clr_i,
  input  logic                             en_i,
  input  logic [sitda_pkg::StepBits-1:0]   cin_i,   // bit per shift, first shift in bit 0
  output logic [sitda_pkg::StepBits-1:0]   cout_o,
  output sitda_pkg::bcd_t                  digit_o
);

  sitda_pkg::bcd_t digit_q, digit_d;

  always_comb begin
    sitda_pkg::bcd_t v;
    sitda_pkg::bcd_t adj;
    v      = digit_q;
    cout_o = '0;
    for (int k = 0; k < sitda_pkg::StepBits; k++) begin
      adj       = (v >= 4'd5) ? v + 4'd3 : v;
      cout_o[k] = adj[3];
      v         = {adj[2:0], cin_i[k]};
    end
    digit_d = v;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      digit_q <= '0;
    end else if (clr_i) begin
      digit_q <= '0;
    end else if (en_i) begin
      digit_q <= digit_d;
    end
  end

  assign digit_o = digit_q;

endmodule

### rtl/core/sitda_conv.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sitda_conv
// magnitude shift register driving a row of digit cells
// ----------------------------------------------------------------------------
module sitda_conv (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [sitda_pkg::ValueWidth-1:0]    in_value_i,
  output logic                                res_valid_o,
  input  logic                                res_ready_i,
  output sitda_pkg::conv_res_t                res_o
);

  localparam int unsigned SW = sitda_pkg::StepBits;

  logic                                 busy_q, busy_d;
  logic                                 full_q, full_d;
  logic                                 neg_q;
  logic [sitda_pkg::StepCntW-1:0]       cnt_q, cnt_d;
  logic [sitda_pkg::ShiftWidth-1:0]     sh_q;
  logic [sitda_pkg::ValueWidth-1:0]     mag;
  logic                                 take, hand, last_step;

  logic [SW-1:0]                        carry [sitda_pkg::NumDigits+1];
  sitda_pkg::bcd_t [sitda_pkg::NumDigits-1:0] digits;

  assign hand       = full_q && res_ready_i;
  assign in_ready_o = !busy_q && (!full_q || hand);
  assign take       = in_valid_i && in_ready_o;
  assign last_step  = (cnt_q == sitda_pkg::StepCntW'(sitda_pkg::NumSteps - 1));
  assign mag        = in_value_i[sitda_pkg::ValueWidth-1] ? (~in_value_i + 1'b1) : in_value_i;

  // msb first: the top slice bit goes in on the first shift
  assign carry[0] = {sh_q[sitda_pkg::ShiftWidth-3], sh_q[sitda_pkg::ShiftWidth-2],
                     sh_q[sitda_pkg::ShiftWidth-1]};

  for (genvar g = 0; g < sitda_pkg::NumDigits; g++) begin : g_cell
    sitda_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .clr_i   (take),
      .en_i    (busy_q),
      .cin_i   (carry[g]),
      .cout_o  (carry[g+1]),
      .digit_o (digits[g])
    );
  end

  always_comb begin
    busy_d = busy_q;
    full_d = full_q;
    cnt_d  = cnt_q;
    if (hand) begin
      full_d = 1'b0;
    end
    if (take) begin
      busy_d = 1'b1;
      cnt_d  = '0;
    end else if (busy_q) begin
      cnt_d = cnt_q + 1'b1;
      if (last_step) begin
        busy_d = 1'b0;
        full_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      full_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      full_q <= full_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      sh_q  <= {{(sitda_pkg::ShiftWidth - sitda_pkg::ValueWidth){1'b0}}, mag};
      neg_q <= in_value_i[sitda_pkg::ValueWidth-1];
    end else if (busy_q) begin
      sh_q <= {sh_q[sitda_pkg::ShiftWidth-SW-1:0], {SW{1'b0}}};
    end
  end

  assign res_valid_o   = full_q;
  assign res_o.neg     = neg_q;
  assign res_o.digits  = digits;

endmodule

### rtl/core/sitda_emit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sitda_emit
// walks a converted number out as characters, dropping leading zeros
// ----------------------------------------------------------------------------
module sitda_emit (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               res_valid_i,
  output logic                               res_ready_o,
  input  sitda_pkg::conv_res_t               res_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [sitda_pkg::CharWidth-1:0]    out_char_o,
  output logic                               out_last_o
);

  logic                                  valid_q, valid_d;
  logic                                  sign_q, sign_d;
  logic [sitda_pkg::DigitIdxW-1:0]       idx_q, idx_d;
  sitda_pkg::bcd_t [sitda_pkg::NumDigits-1:0] dig_q;
  logic [sitda_pkg::DigitIdxW-1:0]       top;
  logic                                  fire, load;

  // highest nonzero digit, zero when the value is zero
  always_comb begin
    top = '0;
    for (int i = 0; i < sitda_pkg::NumDigits; i++) begin
      if (res_i.digits[i] != 4'd0) begin
        top = sitda_pkg::DigitIdxW'(i);
      end
    end
  end

  assign fire        = valid_q && out_ready_i;
  assign res_ready_o = !valid_q || (fire && out_last_o);
  assign load        = res_valid_i && res_ready_o;

  assign out_valid_o = valid_q;
  assign out_char_o  = sign_q ? sitda_pkg::MinusCode
                              : sitda_pkg::ZeroCode + {2'b00, dig_q[idx_q]};
  assign out_last_o  = !sign_q && (idx_q == '0);

  always_comb begin
    valid_d = valid_q;
    sign_d  = sign_q;
    idx_d   = idx_q;
    if (fire) begin
      if (sign_q) begin
        sign_d = 1'b0;
      end else if (idx_q == '0) begin
        valid_d = 1'b0;
      end else begin
        idx_d = idx_q - 1'b1;
      end
    end
    if (load) begin
      valid_d = 1'b1;
      sign_d  = res_i.neg;
      idx_d   = top;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      sign_q  <= 1'b0;
      idx_q   <= '0;
    end else begin
      valid_q <= valid_d;
      sign_q  <= sign_d;
      idx_q   <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      dig_q <= res_i.digits;
    end
  end

endmodule

### verif/signed_int_to_decimal_ascii_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii_test
// self-checking bench for the signed integer to decimal ascii converter:
// values stream in on s_axis, and every character beat on m_axis is compared
// with the decimal text that the bench works out for each accepted value.
// both sides idle at random, in bursts and in quiet stretches.
// ----------------------------------------------------------------------------
module signed_int_to_decimal_ascii_test;

  localparam int unsigned ClkHalf      = 6;
  localparam int unsigned ResetCycles  = 8;
  localparam int unsigned RandomValues = 96;
  localparam int unsigned BurstLen     = 15;
  // conversion plus hand-off plus a full run of characters, with margin
  localparam int unsigned TailCycles   = 40;
  // covers ~120 values of up to 11 beats behind long sink stalls, many times over
  localparam int unsigned CycleLimit   = 400000;

  // one pending value on the input side
  typedef struct {
    logic [sitda_pkg::ValueWidth-1:0] value;
    bit                               drain_first;  // hold off until all text has come out
    int unsigned                      gap_after;    // idle cycles after this beat is taken
  } value_item_t;

  // one expected character beat
  typedef struct {
    logic [sitda_pkg::CharWidth-1:0] code;
    logic                            last;
  } text_char_t;

  logic                             clk_i         = 1'b0;
  logic                             rst_ni        = 1'b0;
  logic                             s_axis_tvalid = 1'b0;
  logic                             s_axis_tready;
  logic [sitda_pkg::ValueWidth-1:0] s_axis_tdata  = '0;   // [31:0] value
  logic                             m_axis_tvalid;
  logic                             m_axis_tready = 1'b0;
  logic [7:0]                       m_axis_tdata;  // [5:0] char_code, [7:6] zero fill
  logic                             m_axis_tlast;  // last_char

  value_item_t value_q[$];      // values not yet presented
  text_char_t  text_exp_q[$];   // characters still owed by the block
  logic        value_taken = 1'b0;
  int unsigned gap_left    = 0;
  int unsigned stall_left  = 0;
  int unsigned cycle_count = 0;
  int unsigned err_count   = 0;
  int unsigned pow10 [10];

  signed_int_to_decimal_ascii DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  initial begin
    forever #(ClkHalf) clk_i = ~clk_i;
  end

  // idle length: mostly none or short, now and then long
  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // decimal text of one value: optional minus sign, then digits with
  // leading zeros dropped; the magnitude is taken as unsigned, so the
  // most negative value spells out without overflow
  function automatic void predict_text(input logic [sitda_pkg::ValueWidth-1:0] value);
    logic                             neg;
    logic [sitda_pkg::ValueWidth-1:0] mag;
    sitda_pkg::bcd_t                  digit [sitda_pkg::NumDigits];
    int                               ndig;
    text_char_t                       ch;
    neg  = value[sitda_pkg::ValueWidth-1];
    mag  = neg ? (~value + 1'b1) : value;
    ndig = 0;
    // least significant digit first; zero still yields one digit
    do begin
      digit[ndig] = sitda_pkg::bcd_t'(mag % 10);
      mag         = mag / 10;
      ndig++;
    end while (mag != 0 && ndig < sitda_pkg::NumDigits);
    if (neg) begin
      ch.code = sitda_pkg::MinusCode;
      ch.last = 1'b0;
      text_exp_q.push_back(ch);
    end
    for (int i = ndig - 1; i >= 0; i--) begin
      ch.code = sitda_pkg::ZeroCode + {2'b00, digit[i]};
      ch.last = (i == 0);
      text_exp_q.push_back(ch);
    end
  endfunction

  function automatic void queue_value(input logic [sitda_pkg::ValueWidth-1:0] value,
                                      input bit drain_first,
                                      input int unsigned gap_after);
    value_item_t item;
    item.value       = value;
    item.drain_first = drain_first;
    item.gap_after   = gap_after;
    value_q.push_back(item);
  endfunction

  // a random value: full-range noise, a chosen digit count, or a
  // neighbor of a power of ten, each with a random sign
  function automatic logic [sitda_pkg::ValueWidth-1:0] random_value();
    logic [sitda_pkg::ValueWidth-1:0] v;
    int unsigned                      ndig;
    int unsigned                      lo;
    int unsigned                      hi;
    case ($urandom_range(0, 3))
      0: begin
        v = $urandom();
      end
      1, 2: begin
        ndig = $urandom_range(1, 10);
        lo   = (ndig == 1) ? 0 : pow10[ndig-1];
        hi   = (ndig == 10) ? 32'h7fff_ffff : pow10[ndig] - 1;
        v    = $urandom_range(hi, lo);
        if ($urandom_range(0, 1) == 1) v = -v;
      end
      default: begin
        v = pow10[$urandom_range(0, 9)] + $urandom_range(0, 2) - 1;
        if ($urandom_range(0, 1) == 1) v = -v;
      end
    endcase
    return v;
  endfunction

  // cycle counter, input acceptance and output checking, all at the rising edge
  always @(posedge clk_i) begin : monitor
    text_char_t want;
    cycle_count <= cycle_count + 1;
    value_taken <= s_axis_tvalid && s_axis_tready;
    if (rst_ni && s_axis_tvalid && s_axis_tready) begin
      predict_text(s_axis_tdata);
    end
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (text_exp_q.size() == 0) begin
        $error("unexpected character beat: char_code %0d, last_char %0b",
               m_axis_tdata[sitda_pkg::CharWidth-1:0], m_axis_tlast);
        err_count++;
      end else begin
        want = text_exp_q.pop_front();
        if (m_axis_tdata[sitda_pkg::CharWidth-1:0] !== want.code) begin
          $error("char_code: expected %0d, actual %0d",
                 want.code, m_axis_tdata[sitda_pkg::CharWidth-1:0]);
          err_count++;
        end
        if (m_axis_tlast !== want.last) begin
          $error("last_char: expected %0b, actual %0b", want.last, m_axis_tlast);
          err_count++;
        end
      end
    end
  end

  // input driver: holds a beat until taken, then idles for the item's gap
  // before presenting the next one; a drain item waits for an empty output side
  always @(negedge clk_i) begin : driver
    value_item_t item;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || value_taken) begin
      if (gap_left != 0) begin
        gap_left--;
        s_axis_tvalid <= 1'b0;
      end else if (value_q.size() == 0 ||
                   (value_q[0].drain_first && text_exp_q.size() != 0)) begin
        s_axis_tvalid <= 1'b0;
      end else begin
        item = value_q.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= item.value;
        gap_left      = item.gap_after;
      end
    end
  end

  // output back-pressure: one stretch in three runs with ready held high
  always @(negedge clk_i) begin : sink
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
      if (((cycle_count / 512) % 3) != 0 && $urandom_range(0, 3) == 0) begin
        stall_left = pick_gap();
      end
    end
  end

  initial begin : stimulus
    bit steady;
    pow10[0] = 1;
    for (int i = 1; i < 10; i++) pow10[i] = pow10[i-1] * 10;

    // directed: first half back to back, then with random gaps
    queue_value(32'd0, 1'b0, 0);                    // zero gives a single '0'
    queue_value(32'd1, 1'b0, 0);
    queue_value(-32'sd1, 1'b0, 0);                  // all ones
    queue_value(32'd9, 1'b0, 0);
    queue_value(32'd10, 1'b0, 0);
    queue_value(-32'sd10, 1'b0, 0);
    queue_value(32'd99, 1'b0, 0);
    queue_value(32'd100, 1'b0, 0);
    queue_value(32'h7fff_ffff, 1'b0, 0);            // largest positive
    queue_value(32'h8000_0000, 1'b0, 0);            // most negative, eleven chars
    queue_value(32'h8000_0001, 1'b0, 0);
    queue_value(32'd1000000000, 1'b0, 0);           // ten digits
    queue_value(32'd999999999, 1'b1, pick_gap());   // sender waits for a drain
    queue_value(-32'sd999999999, 1'b0, pick_gap());
    queue_value(32'd1000000009, 1'b0, pick_gap());
    queue_value(32'd123456789, 1'b0, pick_gap());
    queue_value(-32'sd1234567890, 1'b0, pick_gap());
    queue_value(32'd2147483640, 1'b0, pick_gap());
    queue_value(32'd5, 1'b0, pick_gap());
    queue_value(-32'sd7, 1'b0, pick_gap());
    queue_value(32'h5555_5555, 1'b0, pick_gap());
    queue_value(32'haaaa_aaaa, 1'b0, pick_gap());
    queue_value(32'd65536, 1'b0, pick_gap());
    queue_value(-32'sd65536, 1'b0, pick_gap());

    // random: each burst runs with no gaps or with random gaps, picked at random
    for (int n = 0; n < RandomValues; n++) begin
      if (n % BurstLen == 0) steady = ($urandom_range(0, 2) == 0);
      queue_value(random_value(), ($urandom_range(0, 29) == 0),
                  steady ? 0 : pick_gap());
    end

    repeat (ResetCycles) @(negedge clk_i);
    rst_ni = 1'b1;

    while (value_q.size() != 0 || s_axis_tvalid) @(posedge clk_i);
    while (text_exp_q.size() != 0) @(posedge clk_i);
    repeat (TailCycles) @(posedge clk_i);

    if (err_count == 0) begin
      $display("signed_int_to_decimal_ascii_test: done, clean");
    end else begin
      $display("signed_int_to_decimal_ascii_test: done, errors");
    end
    $finish;
  end

  // hang guard
  initial begin : watchdog
    while (cycle_count < CycleLimit) @(posedge clk_i);
    $error("timeout after %0d cycles, %0d characters still owed",
           cycle_count, text_exp_q.size());
    $display("signed_int_to_decimal_ascii_test: done, errors");
    $finish;
  end

endmodule
